// ===== design/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, codes and helpers of the motor ramp and direction controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned CodeW = 3;
  localparam int unsigned AddrW = 5;
  localparam int unsigned ApbW  = 32;

  typedef logic [DataW-1:0] data_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [2:0]       reg_idx_t;

  // ramp machine states
  localparam code_t ST_STOP  = 3'd0;
  localparam code_t ST_DEC   = 3'd1;
  localparam code_t ST_INC   = 3'd2;
  localparam code_t ST_MAINT = 3'd3;

  // directions
  localparam code_t DIR_NONE  = 3'd0;
  localparam code_t DIR_FWD   = 3'd1;
  localparam code_t DIR_BACK  = 3'd2;
  localparam code_t DIR_LEFT  = 3'd3;
  localparam code_t DIR_RIGHT = 3'd4;

  // register map, index = paddr[4:2]
  localparam reg_idx_t REG_DUTY_STEP        = 3'd0;
  localparam reg_idx_t REG_DUTY_MAX         = 3'd1;
  localparam reg_idx_t REG_COUNTER_RESTART  = 3'd2;
  localparam reg_idx_t REG_START_STATE      = 3'd3;
  localparam reg_idx_t REG_START_DIRECTION  = 3'd4;
  localparam reg_idx_t REG_START_LEFT_DUTY  = 3'd5;
  localparam reg_idx_t REG_START_RIGHT_DUTY = 3'd6;
  localparam reg_idx_t REG_START_COUNTER    = 3'd7;

  localparam data_t DUTY_STEP_RST = 16'd1;
  localparam data_t DUTY_MAX_RST  = 16'd255;
  localparam data_t DATA_ZERO     = 16'd0;

  typedef struct packed {
    data_t duty_step;
    data_t duty_max;
    data_t counter_restart;
  } cfg_t;

  // immediate loads of the machine state from start register writes
  typedef struct packed {
    logic  state_ld;
    logic  dir_ld;
    logic  left_ld;
    logic  right_ld;
    logic  count_ld;
    data_t value;
  } load_t;

  typedef struct packed {
    logic  left_fwd_pin;
    logic  left_rev_pin;
    logic  right_fwd_pin;
    logic  right_rev_pin;
    data_t left_duty_out;
    data_t right_duty_out;
    code_t state_out;
    code_t direction_out;
  } res_t;

  function automatic data_t sat_add16(input data_t a, input data_t b);
    logic [DataW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DataW] ? '1 : sum[DataW-1:0];
  endfunction

  function automatic data_t sat_sub16(input data_t a, input data_t b);
    return (a > b) ? (a - b) : DATA_ZERO;
  endfunction

  // steering wins over acceleration, only zero or sign matters
  function automatic code_t decode_req(input logic signed [DataW-1:0] accel,
                                       input logic signed [DataW-1:0] steer);
    code_t req;
    if (steer != '0) begin
      req = steer[DataW-1] ? DIR_LEFT : DIR_RIGHT;
    end else if (accel != '0) begin
      req = accel[DataW-1] ? DIR_BACK : DIR_FWD;
    end else begin
      req = DIR_NONE;
    end
    return req;
  endfunction

endpackage

`default_nettype wire

// ===== design/mrd_in_if.sv =====
// ----------------------------------------------------------------------------
// mrd_in_if
// Request channel: signed acceleration and steering per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrd_in_if;
  import mrd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] accel_value;
  logic signed [DataW-1:0] steer_value;

  modport source (output valid, output accel_value, output steer_value, input ready);
  modport sink   (input valid, input accel_value, input steer_value, output ready);
endinterface

`default_nettype wire

// ===== design/mrd_out_if.sv =====
// ----------------------------------------------------------------------------
// mrd_out_if
// Result channel: bridge pins, duties, state and held direction per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrd_out_if;
  import mrd_pkg::*;

  logic  valid;
  logic  ready;
  logic  left_fwd_pin;
  logic  left_rev_pin;
  logic  right_fwd_pin;
  logic  right_rev_pin;
  data_t left_duty_out;
  data_t right_duty_out;
  code_t state_out;
  code_t direction_out;

  modport source (output valid, output left_fwd_pin, output left_rev_pin,
                  output right_fwd_pin, output right_rev_pin,
                  output left_duty_out, output right_duty_out,
                  output state_out, output direction_out, input ready);
  modport sink   (input valid, input left_fwd_pin, input left_rev_pin,
                  input right_fwd_pin, input right_rev_pin,
                  input left_duty_out, input right_duty_out,
                  input state_out, input direction_out, output ready);
endinterface

`default_nettype wire

// ===== design/motor_ramp_direction_fsm_core.sv =====
// ----------------------------------------------------------------------------
// motor_ramp_direction_fsm_core
// Motor ramp and direction controller: request decode, ramp machine, duties.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  item_i    in    valid/ready           accel_value, steer_value
//  result_o  out   valid/ready           pins, duties, state_out, direction_out
//  apb       in    psel/penable/pwrite   paddr[4:2] register, pwdata
//
//  one beat per cycle sustained while result_o is not stalled; result_o.valid
//  rises once its beat has passed the request register, then the result register
//  the ramp machine state updates in the same cycle as the result register
//  reset loads the start values; writing a start register loads state at once
//  unless a beat advances in the same cycle, which drops the load; a stalled result
//  holds the result register; the request register still takes one more beat before item_i.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module motor_ramp_direction_fsm_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  mrd_in_if.sink                         item_i,
  mrd_out_if.source                      result_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mrd_pkg::AddrW-1:0] paddr,
  input  wire logic [mrd_pkg::ApbW-1:0]  pwdata,
  output      logic [mrd_pkg::ApbW-1:0]  prdata,
  output      logic                      pready
);
  import mrd_pkg::*;

  cfg_t  cfg;
  load_t load;
  res_t  res;
  logic  req_valid_q, res_valid_q;
  code_t req_q;
  logic  adv, in_fire;

  assign adv          = req_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !req_valid_q || adv;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        req_valid_q <= 1'b1;
      end else if (adv) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= decode_req(item_i.accel_value, item_i.steer_value);
    end
  end

  mrd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .load_o  (load)
  );

  mrd_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .load_i (load),
    .adv_i  (adv),
    .req_i  (req_q),
    .res_o  (res)
  );

  assign result_o.valid          = res_valid_q;
  assign result_o.left_fwd_pin   = res.left_fwd_pin;
  assign result_o.left_rev_pin   = res.left_rev_pin;
  assign result_o.right_fwd_pin  = res.right_fwd_pin;
  assign result_o.right_rev_pin  = res.right_rev_pin;
  assign result_o.left_duty_out  = res.left_duty_out;
  assign result_o.right_duty_out = res.right_duty_out;
  assign result_o.state_out      = res.state_out;
  assign result_o.direction_out  = res.direction_out;

endmodule

`default_nettype wire

// ===== design/mrd_regs.sv =====
// ----------------------------------------------------------------------------
// mrd_regs
// APB register file: ramp settings and start values with immediate load.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [mrd_pkg::AddrW-1:0] paddr,
  input  wire logic [mrd_pkg::ApbW-1:0]  pwdata,
  output      logic [mrd_pkg::ApbW-1:0]  prdata,
  output      logic                  pready,
  output      mrd_pkg::cfg_t         cfg_o,
  output      mrd_pkg::load_t        load_o
);
  import mrd_pkg::*;

  data_t    step_q, max_q, restart_q;
  code_t    st_state_q, st_dir_q;
  data_t    st_left_q, st_right_q, st_count_q;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= DUTY_STEP_RST;
      max_q      <= DUTY_MAX_RST;
      restart_q  <= DATA_ZERO;
      st_state_q <= ST_STOP;
      st_dir_q   <= DIR_NONE;
      st_left_q  <= DATA_ZERO;
      st_right_q <= DATA_ZERO;
      st_count_q <= DATA_ZERO;
    end else if (wr_en) begin
      unique case (idx)
        REG_DUTY_STEP:        step_q     <= pwdata[DataW-1:0];
        REG_DUTY_MAX:         max_q      <= pwdata[DataW-1:0];
        REG_COUNTER_RESTART:  restart_q  <= pwdata[DataW-1:0];
        REG_START_STATE:      st_state_q <= pwdata[CodeW-1:0];
        REG_START_DIRECTION:  st_dir_q   <= pwdata[CodeW-1:0];
        REG_START_LEFT_DUTY:  st_left_q  <= pwdata[DataW-1:0];
        REG_START_RIGHT_DUTY: st_right_q <= pwdata[DataW-1:0];
        REG_START_COUNTER:    st_count_q <= pwdata[DataW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DUTY_STEP:        prdata[DataW-1:0] = step_q;
      REG_DUTY_MAX:         prdata[DataW-1:0] = max_q;
      REG_COUNTER_RESTART:  prdata[DataW-1:0] = restart_q;
      REG_START_STATE:      prdata[CodeW-1:0] = st_state_q;
      REG_START_DIRECTION:  prdata[CodeW-1:0] = st_dir_q;
      REG_START_LEFT_DUTY:  prdata[DataW-1:0] = st_left_q;
      REG_START_RIGHT_DUTY: prdata[DataW-1:0] = st_right_q;
      REG_START_COUNTER:    prdata[DataW-1:0] = st_count_q;
    endcase
  end

  assign cfg_o.duty_step       = step_q;
  assign cfg_o.duty_max        = max_q;
  assign cfg_o.counter_restart = restart_q;

  assign load_o.state_ld = wr_en && (idx == REG_START_STATE);
  assign load_o.dir_ld   = wr_en && (idx == REG_START_DIRECTION);
  assign load_o.left_ld  = wr_en && (idx == REG_START_LEFT_DUTY);
  assign load_o.right_ld = wr_en && (idx == REG_START_RIGHT_DUTY);
  assign load_o.count_ld = wr_en && (idx == REG_START_COUNTER);
  assign load_o.value    = pwdata[DataW-1:0];

endmodule

`default_nettype wire

// ===== design/mrd_ramp.sv =====
// ----------------------------------------------------------------------------
// mrd_ramp
// Ramp machine, ramp counter, duties and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_ramp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mrd_pkg::cfg_t  cfg_i,
  input  wire mrd_pkg::load_t load_i,
  input  wire logic           adv_i,
  input  wire mrd_pkg::code_t req_i,
  output      mrd_pkg::res_t  res_o
);
  import mrd_pkg::*;

  code_t          state_q, dir_q;
  data_t          left_q, right_q, count_q;
  code_t          state_d, dir_d, ns, nd;
  data_t          left_d, right_d, count_d, cnt_new;
  data_t          cnt1, cnt2;
  logic [DataW:0] limit;
  logic           hit1, real_dir, commit;
  res_t           res_d, res_q;

  assign cnt1     = sat_add16(count_q, cfg_i.duty_step);
  assign cnt2     = sat_add16(cnt1, cfg_i.duty_step);
  assign limit    = {1'b0, cfg_i.duty_max} + {1'b0, cfg_i.duty_step};
  assign hit1     = ({1'b0, cnt1} == limit);
  assign real_dir = (dir_q >= DIR_FWD) && (dir_q <= DIR_RIGHT);

  always_comb begin
    ns      = state_q;
    nd      = dir_q;
    cnt_new = count_q;
    commit  = 1'b0;
    unique if (state_q == ST_STOP && dir_q == DIR_NONE && req_i != DIR_NONE) begin
      ns      = ST_INC;
      nd      = req_i;
      cnt_new = cnt1;
      commit  = 1'b1;
    end else if ((state_q == ST_INC || state_q == ST_MAINT) && real_dir) begin
      nd = dir_q;
      if (req_i == dir_q) begin
        ns = ST_MAINT;
        if (state_q == ST_INC) begin
          // ramp up ends only when the counter lands on the limit
          cnt_new = hit1 ? cfg_i.counter_restart : cnt1;
          commit  = hit1;
        end else begin
          commit = 1'b1;
        end
      end else begin
        // leaving increase bumps the counter twice, leaving maintain bumps it once
        ns      = ST_DEC;
        cnt_new = (state_q == ST_INC) ? cnt2 : cnt1;
        commit  = 1'b1;
      end
    end else if (state_q == ST_DEC && real_dir) begin
      ns      = ST_STOP;
      nd      = DIR_NONE;
      cnt_new = hit1 ? cfg_i.counter_restart : cnt1;
      commit  = hit1;
    end else begin
      commit = 1'b0;
    end
  end

  always_comb begin
    state_d = commit ? ns : state_q;
    dir_d   = commit ? nd : dir_q;
    count_d = cnt_new;
    left_d  = left_q;
    right_d = right_q;
    if (state_d == ST_INC) begin
      left_d  = sat_add16(left_q, cfg_i.duty_step);
      right_d = sat_add16(right_q, cfg_i.duty_step);
    end else if (state_d == ST_DEC) begin
      left_d  = sat_sub16(left_q, cfg_i.duty_step);
      right_d = sat_sub16(right_q, cfg_i.duty_step);
    end
  end

  always_comb begin
    res_d                = '0;
    res_d.left_duty_out  = left_d;
    res_d.right_duty_out = right_d;
    res_d.state_out      = state_d;
    res_d.direction_out  = dir_d;
    // none and unknown directions leave every pin low
    unique case (dir_d)
      DIR_FWD: begin
        res_d.left_rev_pin  = 1'b1;
        res_d.right_rev_pin = 1'b1;
      end
      DIR_BACK: begin
        res_d.left_fwd_pin  = 1'b1;
        res_d.right_fwd_pin = 1'b1;
      end
      DIR_LEFT: begin
        res_d.left_fwd_pin  = 1'b1;
        res_d.right_rev_pin = 1'b1;
      end
      DIR_RIGHT: begin
        res_d.left_rev_pin  = 1'b1;
        res_d.right_fwd_pin = 1'b1;
      end
      default: res_d.left_fwd_pin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STOP;
      dir_q   <= DIR_NONE;
      left_q  <= DATA_ZERO;
      right_q <= DATA_ZERO;
      count_q <= DATA_ZERO;
    end else if (adv_i) begin
      state_q <= state_d;
      dir_q   <= dir_d;
      left_q  <= left_d;
      right_q <= right_d;
      count_q <= count_d;
    end else begin
      if (load_i.state_ld) begin
        state_q <= load_i.value[CodeW-1:0];
      end
      if (load_i.dir_ld) begin
        dir_q <= load_i.value[CodeW-1:0];
      end
      if (load_i.left_ld) begin
        left_q <= load_i.value;
      end
      if (load_i.right_ld) begin
        right_q <= load_i.value;
      end
      if (load_i.count_ld) begin
        count_q <= load_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i && !load_i.state_ld && !load_i.dir_ld |=> $stable(state_q) && $stable(dir_q))
    else $error("ramp state moved without a beat or a load");

  a_stop_clears_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && state_q == ST_DEC && state_d == ST_STOP |=> dir_q == DIR_NONE)
    else $error("stop entered with a held direction");

  a_result_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> res_q.state_out == state_q && res_q.direction_out == dir_q
              && res_q.left_duty_out == left_q)
    else $error("result register out of step with machine state");

  a_bridge_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |-> !(res_d.left_fwd_pin && res_d.left_rev_pin)
              && !(res_d.right_fwd_pin && res_d.right_rev_pin))
    else $error("bridge driven high on both pins");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor ramp and direction controller. A short
// table of requests runs at the reset settings, then a series of register
// settings (extremes, stuck codes, random) each carry a random request stream.
// Every result beat is compared field by field with a local model of the ramp
// machine, duties and bridge pins (or a pinned row's result), under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import mrd_pkg::*;

  localparam int    N_PHASES    = 11;
  localparam int    STUCK_PHASE = 4;
  localparam int    HOLD_PHASE  = 6;
  localparam int    HOLD_CYCLES = 300;
  localparam int    WDOG_LIMIT  = 3000;
  localparam int    MAX_PRINTS  = 40;
  localparam code_t ST_BAD      = 3'd4;
  localparam code_t DIR_BAD     = 3'd5;

  localparam res_t RES_AT_RESET  = '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, ST_STOP, DIR_NONE};
  localparam res_t RES_FIRST_FWD = '{1'b0, 1'b1, 1'b0, 1'b1, 16'd1, 16'd1, ST_INC, DIR_FWD};

  typedef struct packed {
    logic signed [DataW-1:0] accel;
    logic signed [DataW-1:0] steer;
    logic                    pinned;
    res_t                    want;
  } opening_row_t;

  localparam int N_OPEN = 17;
  opening_row_t opening_rows [N_OPEN] = '{
    '{16'sh0000, 16'sh0000, 1'b1, RES_AT_RESET},
    '{16'sh7fff, 16'sh0000, 1'b1, RES_FIRST_FWD},
    '{16'sh8000, 16'sh0000, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b0, '0},
    '{16'sh0000, 16'sh8000, 1'b0, '0},
    '{16'sh0000, 16'sh7fff, 1'b0, '0},
    '{16'shffff, 16'sh0000, 1'b0, '0},
    '{16'sh0001, 16'sh0000, 1'b0, '0},
    '{16'sh0000, 16'shffff, 1'b0, '0},
    '{16'sh0000, 16'sh0001, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'sh8000, 16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 16'sh8000, 1'b0, '0},
    '{16'sh5555, 16'shaaaa, 1'b0, '0},
    '{16'shaaaa, 16'sh5555, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [ApbW-1:0]  pwdata;
  logic [ApbW-1:0]  prdata;
  logic             pready;

  mrd_in_if  item_if ();
  mrd_out_if res_if ();

  motor_ramp_direction_fsm_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of the controller
  data_t cfg_step    = DUTY_STEP_RST;
  data_t cfg_max     = DUTY_MAX_RST;
  data_t cfg_restart = DATA_ZERO;
  code_t mot_state   = ST_STOP;
  code_t mot_dir     = DIR_NONE;
  data_t duty_l      = DATA_ZERO;
  data_t duty_r      = DATA_ZERO;
  data_t ramp_cnt    = DATA_ZERO;

  res_t  pending_res_q [$];
  bit    pinned;
  res_t  pinned_res;
  int    tx_gap_max;
  int    rx_gap_max;
  int    hold_len;
  int    err_cnt;
  int    items_sent;
  int    results_checked;
  int    settings_run;

  function automatic data_t up_sat(input data_t x, input data_t d);
    logic [DataW:0] t;
    t = {1'b0, x} + {1'b0, d};
    return t[DataW] ? '1 : t[DataW-1:0];
  endfunction

  function automatic data_t down_sat(input data_t x, input data_t d);
    return (x > d) ? data_t'(x - d) : DATA_ZERO;
  endfunction

  function automatic res_t step_motor(input logic signed [DataW-1:0] a,
                                      input logic signed [DataW-1:0] s);
    code_t          want;
    code_t          nxt_state;
    code_t          nxt_dir;
    logic [DataW:0] ramp_limit;
    logic           go;
    logic           held_real;
    res_t           r;
    if (s != '0) want = s[DataW-1] ? DIR_LEFT : DIR_RIGHT;
    else if (a != '0) want = a[DataW-1] ? DIR_BACK : DIR_FWD;
    else want = DIR_NONE;

    ramp_limit = {1'b0, cfg_max} + {1'b0, cfg_step};
    held_real  = (mot_dir >= DIR_FWD) && (mot_dir <= DIR_RIGHT);
    go         = 1'b1;
    nxt_state  = mot_state;
    nxt_dir    = mot_dir;
    if (mot_state == ST_STOP && mot_dir == DIR_NONE && want != DIR_NONE) begin
      nxt_state = ST_INC;
      nxt_dir   = want;
    end else if ((mot_state == ST_INC || mot_state == ST_MAINT) && held_real) begin
      nxt_state = (want == mot_dir) ? ST_MAINT : ST_DEC;
    end else if (mot_state == ST_DEC && held_real) begin
      nxt_state = ST_STOP;
      nxt_dir   = DIR_NONE;
    end else begin
      go = 1'b0;
    end

    // ramp counter gates leaving increase and decrease
    if (go) begin
      if (mot_state == ST_INC || nxt_state == ST_INC) ramp_cnt = up_sat(ramp_cnt, cfg_step);
      if (mot_state == ST_INC && nxt_state == ST_MAINT) begin
        if ({1'b0, ramp_cnt} != ramp_limit) go = 1'b0;
        else ramp_cnt = cfg_restart;
      end
    end
    if (go) begin
      if (mot_state == ST_DEC || nxt_state == ST_DEC) ramp_cnt = up_sat(ramp_cnt, cfg_step);
      if (mot_state == ST_DEC && nxt_state == ST_STOP) begin
        if ({1'b0, ramp_cnt} != ramp_limit) go = 1'b0;
        else ramp_cnt = cfg_restart;
      end
    end
    if (go) begin
      mot_state = nxt_state;
      mot_dir   = nxt_dir;
    end

    r = '0;
    case (mot_dir)
      DIR_FWD: begin
        r.left_rev_pin  = 1'b1;
        r.right_rev_pin = 1'b1;
      end
      DIR_BACK: begin
        r.left_fwd_pin  = 1'b1;
        r.right_fwd_pin = 1'b1;
      end
      DIR_LEFT: begin
        r.left_fwd_pin  = 1'b1;
        r.right_rev_pin = 1'b1;
      end
      DIR_RIGHT: begin
        r.left_rev_pin  = 1'b1;
        r.right_fwd_pin = 1'b1;
      end
      default: ;
    endcase

    if (mot_state == ST_INC) begin
      duty_l = up_sat(duty_l, cfg_step);
      duty_r = up_sat(duty_r, cfg_step);
    end else if (mot_state == ST_DEC) begin
      duty_l = down_sat(duty_l, cfg_step);
      duty_r = down_sat(duty_r, cfg_step);
    end
    r.left_duty_out  = duty_l;
    r.right_duty_out = duty_r;
    r.state_out      = mot_state;
    r.direction_out  = mot_dir;
    return r;
  endfunction

  // start registers load the machine at once
  function automatic void apply_reg(input reg_idx_t idx, input data_t val);
    case (idx)
      REG_DUTY_STEP:        cfg_step    = val;
      REG_DUTY_MAX:         cfg_max     = val;
      REG_COUNTER_RESTART:  cfg_restart = val;
      REG_START_STATE:      mot_state   = val[CodeW-1:0];
      REG_START_DIRECTION:  mot_dir     = val[CodeW-1:0];
      REG_START_LEFT_DUTY:  duty_l      = val;
      REG_START_RIGHT_DUTY: duty_r      = val;
      REG_START_COUNTER:    ramp_cnt    = val;
      default: ;
    endcase
  endfunction

  // mostly keeps asking for the held direction so ramps run to completion
  function automatic void pick_request(output logic signed [DataW-1:0] a,
                                       output logic signed [DataW-1:0] s);
    int    roll;
    code_t d;
    roll = $urandom_range(0, 99);
    a    = DataW'($urandom);
    s    = DataW'($urandom);
    if (roll < 90) begin
      if (roll < 65 && mot_dir >= DIR_FWD && mot_dir <= DIR_RIGHT) d = mot_dir;
      else if (roll < 80) d = code_t'($urandom_range(DIR_FWD, DIR_RIGHT));
      else d = DIR_NONE;
      case (d)
        DIR_FWD: begin
          s          = '0;
          a[DataW-1] = 1'b0;
          if (a == '0) a = 16'sd1;
        end
        DIR_BACK: begin
          s          = '0;
          a[DataW-1] = 1'b1;
        end
        DIR_LEFT: s[DataW-1] = 1'b1;
        DIR_RIGHT: begin
          s[DataW-1] = 1'b0;
          if (s == '0) s = 16'sd1;
        end
        default: begin
          a = '0;
          s = '0;
        end
      endcase
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t result %0d: %s got %0h expected %0h", $time, results_checked, what, got, want);
    end
    err_cnt++;
  endtask

  task automatic reg_write(input reg_idx_t idx, input data_t val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(ApbW-DataW){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_setting(input data_t step, input data_t max, input data_t restart,
                                 input code_t st, input code_t dir, input data_t ld,
                                 input data_t rd, input data_t cnt);
    reg_write(REG_DUTY_STEP, step);
    reg_write(REG_DUTY_MAX, max);
    reg_write(REG_COUNTER_RESTART, restart);
    reg_write(REG_START_STATE, data_t'(st));
    reg_write(REG_START_DIRECTION, data_t'(dir));
    reg_write(REG_START_LEFT_DUTY, ld);
    reg_write(REG_START_RIGHT_DUTY, rd);
    reg_write(REG_START_COUNTER, cnt);
    settings_run++;
  endtask

  task automatic apply_phase(input int p);
    data_t step;
    data_t max;
    case (p)
      0: program_setting(16'd1, 16'd2, 16'd0, ST_STOP, DIR_NONE, 16'd0, 16'd0, 16'd0);
      1: program_setting(16'hffff, 16'hffff, 16'hffff, ST_INC, DIR_RIGHT,
                         16'hffff, 16'hffff, 16'hffff);
      2: program_setting(16'd0, 16'd0, 16'd0, ST_STOP, DIR_NONE, 16'd0, 16'd0, 16'd0);
      3: program_setting(16'd3, 16'd65532, 16'd65530, ST_MAINT, DIR_LEFT,
                         16'd100, 16'd65534, 16'd65530);
      STUCK_PHASE: program_setting(16'd1, 16'd4, 16'd0, ST_BAD, DIR_BAD, 16'd7, 16'd9, 16'd0);
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          program_setting(data_t'($urandom), data_t'($urandom), data_t'($urandom),
                          code_t'($urandom_range(ST_STOP, ST_BAD)),
                          code_t'($urandom_range(DIR_NONE, DIR_BAD)),
                          data_t'($urandom), data_t'($urandom), data_t'($urandom));
        end else begin
          step = data_t'($urandom_range(0, 4));
          max  = data_t'($urandom_range(0, 12));
          program_setting(step, max, data_t'($urandom_range(0, max)),
                          code_t'($urandom_range(ST_STOP, ST_BAD)),
                          code_t'($urandom_range(DIR_NONE, DIR_BAD)),
                          data_t'($urandom), data_t'($urandom),
                          data_t'($urandom_range(0, 12)));
        end
      end
    endcase
    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
  endtask

  task automatic send_item(input bit rnd, input logic signed [DataW-1:0] a_in,
                           input logic signed [DataW-1:0] s_in, input bit pin,
                           input res_t pin_val);
    int                      gap;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] s;
    @(negedge clk_i);
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (rnd) begin
      pick_request(a, s);
    end else begin
      a = a_in;
      s = s_in;
    end
    pinned     = pin;
    pinned_res = pin_val;
    item_if.accel_value <= a;
    item_if.steer_value <= s;
    item_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
  endtask

  task automatic finish_phase();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result check first, then the new request beat of the same edge
  always @(posedge clk_i) begin : beat_monitor
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.left_fwd_pin, res_if.left_rev_pin, res_if.right_fwd_pin,
                res_if.right_rev_pin, res_if.left_duty_out, res_if.right_duty_out,
                res_if.state_out, res_if.direction_out};
        results_checked++;
        if (pending_res_q.size() == 0) begin
          report("result beat with nothing pending", '0, '0);
        end else begin
          want = pending_res_q.pop_front();
          if (got.left_fwd_pin != want.left_fwd_pin)
            report("left_fwd_pin", 32'(got.left_fwd_pin), 32'(want.left_fwd_pin));
          if (got.left_rev_pin != want.left_rev_pin)
            report("left_rev_pin", 32'(got.left_rev_pin), 32'(want.left_rev_pin));
          if (got.right_fwd_pin != want.right_fwd_pin)
            report("right_fwd_pin", 32'(got.right_fwd_pin), 32'(want.right_fwd_pin));
          if (got.right_rev_pin != want.right_rev_pin)
            report("right_rev_pin", 32'(got.right_rev_pin), 32'(want.right_rev_pin));
          if (got.left_duty_out != want.left_duty_out)
            report("left_duty_out", 32'(got.left_duty_out), 32'(want.left_duty_out));
          if (got.right_duty_out != want.right_duty_out)
            report("right_duty_out", 32'(got.right_duty_out), 32'(want.right_duty_out));
          if (got.state_out != want.state_out)
            report("state_out", 32'(got.state_out), 32'(want.state_out));
          if (got.direction_out != want.direction_out)
            report("direction_out", 32'(got.direction_out), 32'(want.direction_out));
        end
      end
      if (item_if.valid && item_if.ready) begin
        want = step_motor(item_if.accel_value, item_if.steer_value);
        pending_res_q.push_back(pinned ? pinned_res : want);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : watchdog
    int quiet;
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("stalled for %0d cycles, %0d results pending", quiet, pending_res_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item_if.valid       = 1'b0;
    item_if.accel_value = '0;
    item_if.steer_value = '0;
    pinned              = 1'b0;
    pinned_res          = '0;
    hold_len            = 0;
    tx_gap_max          = 8;
    rx_gap_max          = 8;
    err_cnt             = 0;
    items_sent          = 0;
    results_checked     = 0;
    settings_run        = 0;
    rst_ni              = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      send_item(1'b0, opening_rows[i].accel, opening_rows[i].steer,
                opening_rows[i].pinned, opening_rows[i].want);
    end
    finish_phase();

    for (int p = 0; p < N_PHASES; p++) begin
      apply_phase(p);
      // receiver stops while requests keep coming, so the pipe backs up
      if (p == HOLD_PHASE) hold_len = HOLD_CYCLES;
      n = (p == STUCK_PHASE) ? 60 : 180;
      repeat (n) send_item(1'b1, '0, '0, 1'b0, '0);
      finish_phase();
    end
    repeat (10) @(posedge clk_i);

    $display("%0d requests sent over %0d register settings plus reset defaults",
             items_sent, settings_run);
    $display("%0d result beats compared, %0d field mismatches", results_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
